// ===== design/das_pkg.sv =====
// ----------------------------------------------------------------------------
// das_pkg
// Types and constants shared by the door alarm supervisor modules.
// ----------------------------------------------------------------------------
package das_pkg;

    // One input word: a poll reply or an operator accept command.
    typedef struct packed {
        logic        func;
        logic        reply_empty;
        logic [7:0]  function_code;
        logic [7:0]  byte_count;
        logic [15:0] register_word;
        logic [31:0] now_seconds;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [2:0] door_state;
        logic       state_changed;
        logic       raise_alarm;
        logic       log_open_event;
        logic       accept_offered;
        logic       link_good;
        logic       door_is_open;
    } t_out_word;

    // Configuration register values.
    typedef struct packed {
        logic [31:0] grace_delay;
        logic [7:0]  retry_limit;
        logic        supervision_off;
    } t_cfg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRACE_DELAY     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_LIMIT     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SUPERVISION_OFF = 2'd2;

    localparam logic [31:0] GRACE_DELAY_RST     = 32'd60;
    localparam logic [7:0]  RETRY_LIMIT_RST     = 8'd3;
    localparam logic        SUPERVISION_OFF_RST = 1'b0;

    // Door state codes as seen on the result word.
    localparam logic [2:0] CODE_OFFLINE    = 3'd0;
    localparam logic [2:0] CODE_EXCEPTION  = 3'd1;
    localparam logic [2:0] CODE_CLOSED     = 3'd2;
    localparam logic [2:0] CODE_OPEN_UNACK = 3'd3;
    localparam logic [2:0] CODE_OPEN_ACK   = 3'd4;

    localparam int         EXC_BIT_POS     = 7;
    localparam logic [7:0] FUNC_READ_INPUT = 8'h04;
    localparam logic [7:0] WANTED_BYTES    = 8'd2;
    localparam int         FAIL_COUNT_W    = 9;
    localparam logic [FAIL_COUNT_W-1:0] FAIL_COUNT_MAX = 9'd511;
    localparam logic [FAIL_COUNT_W-1:0] FAIL_COUNT_BOUND = 9'd256;

    typedef enum logic [4:0] {
        ST_OFFLINE    = 5'b00001,
        ST_EXCEPTION  = 5'b00010,
        ST_CLOSED     = 5'b00100,
        ST_OPEN_UNACK = 5'b01000,
        ST_OPEN_ACK   = 5'b10000
    } t_fsm_state;

endpackage

// ===== design/door_alarm_supervisor.sv =====
// ----------------------------------------------------------------------------
// door_alarm_supervisor
// Polled door sensor supervisor: link health, retry counting and alarm FSM.
// ----------------------------------------------------------------------------
//   channel   direction   signals                               width
//   in        to block    i_in_valid, o_in_stall, i_in_word     66
//   out       from block  o_out_valid, i_out_stall, o_out_word  9
//   cfg       to block    i_cfg_we, i_cfg_index, i_cfg_data     2 + 32
//
// One word is taken per cycle while the input side is not stalled. An accepted
// word is held in the input register; its result word is computed by the
// combinational state step and offered from the result register that follows.
// Reset is synchronous and active low; it empties both registers and returns
// the state machine to offline. A stall on the result side holds the result
// register and, once the input register is full, stalls the input side.
// ----------------------------------------------------------------------------
module door_alarm_supervisor
    import das_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_out_word              o_out_word,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      advance;
    logic      fire;
    logic      in_take;
    t_cfg      cfg;
    t_out_word result;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    das_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    das_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in_word),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take)   r_in_valid <= 1'b1;
            else if (fire) r_in_valid <= 1'b0;
            if (fire)         r_out_valid <= 1'b1;
            else if (advance) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) r_in_word  <= i_in_word;
        if (fire)    r_out_word <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The input side stalls only while a word waits behind a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a held result");

endmodule

// ===== design/das_cfg.sv =====
// ----------------------------------------------------------------------------
// das_cfg
// Configuration registers of the door alarm supervisor.
// ----------------------------------------------------------------------------
module das_cfg
    import das_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_delay     <= GRACE_DELAY_RST;
            r_cfg.retry_limit     <= RETRY_LIMIT_RST;
            r_cfg.supervision_off <= SUPERVISION_OFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRACE_DELAY:     r_cfg.grace_delay     <= i_cfg_data;
                CFG_RETRY_LIMIT:     r_cfg.retry_limit     <= i_cfg_data[7:0];
                CFG_SUPERVISION_OFF: r_cfg.supervision_off <= i_cfg_data[0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/das_core.sv =====
// ----------------------------------------------------------------------------
// das_core
// Link flags, retry counter, fault stamp and the alarm state machine.
// Computes one result word per word taken from the input register.
// ----------------------------------------------------------------------------
module das_core
    import das_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    input  t_cfg      i_cfg,
    output t_out_word o_result
);

    t_fsm_state              r_state, n_state;
    logic                    r_online, n_online;
    logic                    r_link, n_link;
    logic                    r_open, n_open;
    logic [FAIL_COUNT_W-1:0] r_fail_count, n_fail_count;
    logic [31:0]             r_fault_stamp, n_fault_stamp;

    logic [33:0]             grace_diff;
    logic                    grace_old;
    t_fsm_state              step1;
    t_fsm_state              step2;
    logic                    stamp1;
    logic                    stamp2;
    logic                    skip;
    logic                    from_reply;
    logic                    changed;
    logic                    entered;
    logic [FAIL_COUNT_W-1:0] fail_bumped;

    function automatic t_fsm_state next_state(
        input t_fsm_state prev,
        input logic       online,
        input logic       link,
        input logic       open_f,
        input logic       accept,
        input logic       sup_off,
        input logic       grace
    );
        t_fsm_state nxt;
        nxt = prev;
        unique case (prev)
            ST_OFFLINE: begin
                if (online && !link)        nxt = ST_EXCEPTION;
                else if (online && !open_f) nxt = ST_CLOSED;
                else if (online)            nxt = grace ? ST_OPEN_ACK : ST_OPEN_UNACK;
            end
            ST_EXCEPTION: begin
                if (!online)               nxt = ST_OFFLINE;
                else if (link && !open_f)  nxt = ST_CLOSED;
                else if (link)             nxt = grace ? ST_OPEN_ACK : ST_OPEN_UNACK;
            end
            ST_CLOSED: begin
                if (!online)     nxt = ST_OFFLINE;
                else if (!link)  nxt = ST_EXCEPTION;
                else if (open_f) nxt = ST_OPEN_UNACK;
            end
            ST_OPEN_UNACK: begin
                if (!online)                nxt = ST_OFFLINE;
                else if (!link)             nxt = ST_EXCEPTION;
                else if (accept || sup_off) nxt = ST_OPEN_ACK;
            end
            ST_OPEN_ACK: begin
                if (!online)      nxt = ST_OFFLINE;
                else if (!link)   nxt = ST_EXCEPTION;
                else if (!open_f) nxt = ST_CLOSED;
            end
            default: nxt = ST_OFFLINE;
        endcase
        return nxt;
    endfunction

    function automatic logic [2:0] state_code(input t_fsm_state st);
        logic [2:0] code;
        unique case (st)
            ST_OFFLINE:    code = CODE_OFFLINE;
            ST_EXCEPTION:  code = CODE_EXCEPTION;
            ST_CLOSED:     code = CODE_CLOSED;
            ST_OPEN_UNACK: code = CODE_OPEN_UNACK;
            ST_OPEN_ACK:   code = CODE_OPEN_ACK;
            default:       code = CODE_OFFLINE;
        endcase
        return code;
    endfunction

    // Signed distance from the fault stamp; a time before the stamp is inside.
    assign grace_diff = {2'b00, i_word.now_seconds} - {2'b00, r_fault_stamp};
    assign grace_old  = $signed(grace_diff) <= $signed({2'b00, i_cfg.grace_delay});

    assign fail_bumped = (r_fail_count < FAIL_COUNT_MAX) ? r_fail_count + FAIL_COUNT_W'(1)
                                                         : r_fail_count;

    always_comb begin
        n_online      = r_online;
        n_link        = r_link;
        n_open        = r_open;
        n_fail_count  = r_fail_count;
        n_fault_stamp = r_fault_stamp;
        skip          = 1'b0;
        from_reply    = 1'b0;
        step1         = r_state;
        step2         = r_state;
        stamp1        = 1'b0;
        stamp2        = 1'b0;

        if (i_word.func) begin
            // Acknowledge step, then a refresh step. A stamp taken in the first
            // step puts the second one at distance zero, inside the window.
            step1  = next_state(r_state, r_online, r_link, r_open, 1'b1,
                                i_cfg.supervision_off, grace_old);
            stamp1 = (step1 != r_state) &&
                     ((step1 == ST_OFFLINE) || (step1 == ST_EXCEPTION));
            step2  = next_state(step1, r_online, r_link, r_open, 1'b0,
                                i_cfg.supervision_off, grace_old || stamp1);
            stamp2 = (step2 != step1) &&
                     ((step2 == ST_OFFLINE) || (step2 == ST_EXCEPTION));
        end else begin
            if (i_word.reply_empty) begin
                if (r_fail_count > {1'b0, i_cfg.retry_limit}) n_link = 1'b0;
                else                                          n_fail_count = fail_bumped;
            end else begin
                if (i_word.function_code[EXC_BIT_POS]) begin
                    if ((r_fail_count > {1'b0, i_cfg.retry_limit}) || !r_online) begin
                        n_link       = 1'b0;
                        n_fail_count = '0;
                    end else begin
                        n_fail_count = fail_bumped;
                    end
                end else begin
                    n_link       = 1'b1;
                    n_fail_count = '0;
                end
                n_online = 1'b1;
                if (i_word.function_code == FUNC_READ_INPUT) begin
                    if (i_word.byte_count != WANTED_BYTES) begin
                        n_link = 1'b0;
                        skip   = 1'b1;
                    end else begin
                        n_open = i_word.register_word[0];
                    end
                end
            end
            if (!skip) begin
                from_reply = 1'b1;
                step2  = next_state(r_state, n_online, n_link, n_open, 1'b0,
                                    i_cfg.supervision_off, grace_old);
                stamp2 = (step2 != r_state) &&
                         ((step2 == ST_OFFLINE) || (step2 == ST_EXCEPTION));
            end
        end

        n_state = step2;
        if (stamp1 || stamp2) n_fault_stamp = i_word.now_seconds;
    end

    assign changed = (n_state != r_state);
    assign entered = from_reply && changed && (n_state == ST_OPEN_UNACK);

    assign o_result.door_state     = state_code(n_state);
    assign o_result.state_changed  = changed;
    assign o_result.raise_alarm    = entered && !i_cfg.supervision_off;
    assign o_result.log_open_event = entered;
    assign o_result.accept_offered = (n_state == ST_OPEN_UNACK);
    assign o_result.link_good      = n_link;
    assign o_result.door_is_open   = n_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_OFFLINE;
            r_online      <= 1'b0;
            r_link        <= 1'b0;
            r_open        <= 1'b0;
            r_fail_count  <= '0;
            r_fault_stamp <= '0;
        end else if (i_fire) begin
            r_state       <= n_state;
            r_online      <= n_online;
            r_link        <= n_link;
            r_open        <= n_open;
            r_fail_count  <= n_fail_count;
            r_fault_stamp <= n_fault_stamp;
        end
    end

    // The counter only counts while it is at or below an 8-bit limit.
    a_fail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fail_count <= FAIL_COUNT_BOUND)
        else $error("retry counter passed its bound");

    // Every state other than offline is reached only once the device answered.
    a_online_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_OFFLINE) |-> r_online)
        else $error("left offline without the device online");

    // An accept command never changes the link or door flags.
    a_accept_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_word.func) |=> ($stable(r_link) && $stable(r_open)))
        else $error("accept command changed a link or door flag");

endmodule

// ===== verif/door_alarm_supervisor_checker.sv =====
// ----------------------------------------------------------------------------
// door_alarm_supervisor_checker
// Watches the word, result and register ports of the door alarm supervisor.
// It keeps its own copy of the link flags, retry counter, alarm state and
// registers, predicts one result word per accepted input word, and compares
// every accepted result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module door_alarm_supervisor_checker
    import das_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  t_in_word               i_in_word,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  t_out_word              i_out_word,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_mismatches,
    output int                     o_pending
);

    logic [31:0]             grace_delay;
    logic [7:0]              retry_limit;
    logic                    supervision_off;

    t_fsm_state              door_fsm;
    logic                    online_flag;
    logic                    link_flag;
    logic                    open_flag;
    logic [FAIL_COUNT_W-1:0] fail_count;
    logic [31:0]             fault_stamp;

    t_out_word               pending_door_results[$];
    int                      mismatch_count = 0;
    int                      pending_count = 0;
    int                      result_index = 0;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_index, name, got, want));
    endtask

    function automatic void bump_fail_count();
        if (fail_count != FAIL_COUNT_MAX)
            fail_count++;
    endfunction

    // A time before the fault stamp counts as inside the grace window.
    function automatic t_fsm_state next_door_state(input logic accept,
                                                   input logic [31:0] now);
        logic       in_grace;
        t_fsm_state nxt;
        in_grace = (longint'(now) - longint'(fault_stamp)) <= longint'(grace_delay);
        nxt = door_fsm;
        case (door_fsm)
            ST_OFFLINE: begin
                if (online_flag && !link_flag)
                    nxt = ST_EXCEPTION;
                else if (online_flag && !open_flag)
                    nxt = ST_CLOSED;
                else if (online_flag)
                    nxt = in_grace ? ST_OPEN_ACK : ST_OPEN_UNACK;
            end
            ST_EXCEPTION: begin
                if (!online_flag)
                    nxt = ST_OFFLINE;
                else if (link_flag && !open_flag)
                    nxt = ST_CLOSED;
                else if (link_flag)
                    nxt = in_grace ? ST_OPEN_ACK : ST_OPEN_UNACK;
            end
            ST_CLOSED: begin
                if (!online_flag)
                    nxt = ST_OFFLINE;
                else if (!link_flag)
                    nxt = ST_EXCEPTION;
                else if (open_flag)
                    nxt = ST_OPEN_UNACK;
            end
            ST_OPEN_UNACK: begin
                if (!online_flag)
                    nxt = ST_OFFLINE;
                else if (!link_flag)
                    nxt = ST_EXCEPTION;
                else if (accept || supervision_off)
                    nxt = ST_OPEN_ACK;
            end
            default: begin
                if (!online_flag)
                    nxt = ST_OFFLINE;
                else if (!link_flag)
                    nxt = ST_EXCEPTION;
                else if (!open_flag)
                    nxt = ST_CLOSED;
            end
        endcase
        return nxt;
    endfunction

    function automatic void take_step(input logic accept, input logic [31:0] now);
        t_fsm_state nxt;
        nxt = next_door_state(accept, now);
        if (nxt != door_fsm && (nxt == ST_OFFLINE || nxt == ST_EXCEPTION))
            fault_stamp = now;
        door_fsm = nxt;
    endfunction

    function automatic t_out_word predict_door_result(input t_in_word w);
        t_fsm_state before_state;
        logic       from_reply;
        logic       skip_step;
        logic       entered;
        t_out_word  r;
        before_state = door_fsm;
        from_reply   = 1'b0;
        skip_step    = 1'b0;
        if (w.func) begin
            // Operator accept: an acknowledge step, then a refresh step.
            take_step(1'b1, w.now_seconds);
            take_step(1'b0, w.now_seconds);
        end else begin
            if (w.reply_empty) begin
                if (fail_count > retry_limit)
                    link_flag = 1'b0;
                else
                    bump_fail_count();
            end else begin
                if (w.function_code[EXC_BIT_POS]) begin
                    if (fail_count > retry_limit || !online_flag) begin
                        link_flag  = 1'b0;
                        fail_count = '0;
                    end else begin
                        bump_fail_count();
                    end
                end else begin
                    link_flag  = 1'b1;
                    fail_count = '0;
                end
                online_flag = 1'b1;
                if (w.function_code == FUNC_READ_INPUT) begin
                    if (w.byte_count != WANTED_BYTES) begin
                        link_flag = 1'b0;
                        skip_step = 1'b1;
                    end else begin
                        open_flag = w.register_word[0];
                    end
                end
            end
            if (!skip_step) begin
                take_step(1'b0, w.now_seconds);
                from_reply = 1'b1;
            end
        end

        entered = from_reply && door_fsm != before_state && door_fsm == ST_OPEN_UNACK;
        case (door_fsm)
            ST_OFFLINE:    r.door_state = CODE_OFFLINE;
            ST_EXCEPTION:  r.door_state = CODE_EXCEPTION;
            ST_CLOSED:     r.door_state = CODE_CLOSED;
            ST_OPEN_UNACK: r.door_state = CODE_OPEN_UNACK;
            default:       r.door_state = CODE_OPEN_ACK;
        endcase
        r.state_changed  = door_fsm != before_state;
        r.raise_alarm    = entered && !supervision_off;
        r.log_open_event = entered;
        r.accept_offered = door_fsm == ST_OPEN_UNACK;
        r.link_good      = link_flag;
        r.door_is_open   = open_flag;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            grace_delay     = GRACE_DELAY_RST;
            retry_limit     = RETRY_LIMIT_RST;
            supervision_off = SUPERVISION_OFF_RST;
            door_fsm        = ST_OFFLINE;
            online_flag     = 1'b0;
            link_flag       = 1'b0;
            open_flag       = 1'b0;
            fail_count      = '0;
            fault_stamp     = '0;
            pending_door_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRACE_DELAY:     grace_delay = i_cfg_data;
                    CFG_RETRY_LIMIT:     retry_limit = i_cfg_data[7:0];
                    CFG_SUPERVISION_OFF: supervision_off = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                pending_door_results.insert(pending_door_results.size(),
                                            predict_door_result(i_in_word));
            if (i_out_valid && !i_out_stall) begin
                if (pending_door_results.size() == 0) begin
                    report_mismatch($sformatf("result word %h with no input word waiting",
                                              i_out_word));
                end else begin
                    want = pending_door_results.pop_front();
                    check_field("door_state", int'(i_out_word.door_state),
                                int'(want.door_state));
                    check_field("state_changed", int'(i_out_word.state_changed),
                                int'(want.state_changed));
                    check_field("raise_alarm", int'(i_out_word.raise_alarm),
                                int'(want.raise_alarm));
                    check_field("log_open_event", int'(i_out_word.log_open_event),
                                int'(want.log_open_event));
                    check_field("accept_offered", int'(i_out_word.accept_offered),
                                int'(want.accept_offered));
                    check_field("link_good", int'(i_out_word.link_good),
                                int'(want.link_good));
                    check_field("door_is_open", int'(i_out_word.door_is_open),
                                int'(want.door_is_open));
                end
                result_index++;
            end
        end
        pending_count = pending_door_results.size();
    end

endmodule

// ===== verif/door_alarm_supervisor_tb.sv =====
// ----------------------------------------------------------------------------
// door_alarm_supervisor_tb
// Drives the door alarm supervisor with a directed run through the alarm
// states, then random poll replies and accept commands under several register
// settings, with bursty input, random output stalls and long hold-offs. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module door_alarm_supervisor_tb;
    import das_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         HOLD_CYCLES  = 150;
    localparam logic       FUNC_POLL    = 1'b0;
    localparam logic       FUNC_ACCEPT  = 1'b1;
    localparam logic [7:0] EXC_FLAG     = 8'h01 << EXC_BIT_POS;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    t_in_word               in_word;
    logic                   out_valid;
    logic                   out_stall;
    t_out_word              out_word;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     pending;

    int                     cycle_count = 0;
    int                     burst_left = 0;
    logic [31:0]            sim_now = 32'd0;
    logic                   hold_req = 1'b0;

    door_alarm_supervisor DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    door_alarm_supervisor_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Output side: randomly chosen stall styles, and a long hold-off whenever
    // the stimulus asks for one.
    initial begin : receiver
        int stall_style;
        int style_left;
        int hold_count;
        int phase_count;
        stall_style = 0;
        style_left  = 0;
        phase_count = 0;
        out_stall   = 1'b0;
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(posedge clk);
                    hold_count++;
                end
                hold_req = 1'b0;
            end else begin
                if (style_left == 0) begin
                    stall_style = $urandom_range(0, 3);
                    style_left  = $urandom_range(16, 96);
                end
                style_left--;
                phase_count++;
                case (stall_style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (phase_count % 3 == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic t_in_word make_word(input logic func, input logic empty,
                                           input logic [7:0] fcode,
                                           input logic [7:0] bcount,
                                           input logic [15:0] regw,
                                           input logic [31:0] now);
        t_in_word w;
        w.func          = func;
        w.reply_empty   = empty;
        w.function_code = fcode;
        w.byte_count    = bcount;
        w.register_word = regw;
        w.now_seconds   = now;
        return w;
    endfunction

    // Good function-4 replies lead the mix; time creeps forward with an
    // occasional jump so words land both inside and outside the grace window.
    function automatic t_in_word next_poll_word();
        t_in_word w;
        int       pick;
        if ($urandom_range(0, 15) == 0)
            sim_now = $urandom;
        else
            sim_now = sim_now + $urandom_range(0, 45);
        w = make_word(FUNC_POLL, 1'b0, 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), sim_now);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            w.func        = FUNC_ACCEPT;
            w.reply_empty = 1'($urandom_range(0, 1));
        end else if (pick < 25) begin
            w.reply_empty = 1'b1;
        end else if (pick < 35) begin
            w.function_code[EXC_BIT_POS] = 1'b1;
        end else if (pick < 75) begin
            w.function_code = FUNC_READ_INPUT;
            w.byte_count    = WANTED_BYTES;
        end else if (pick < 83) begin
            w.function_code = FUNC_READ_INPUT;
        end else begin
            w.function_code[EXC_BIT_POS] = 1'b0;
        end
        return w;
    endfunction

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic offer_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word  <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] grace, input logic [7:0] limit,
                             input logic sup_off);
        write_reg(CFG_GRACE_DELAY, grace);
        write_reg(CFG_RETRY_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_SUPERVISION_OFF, CFG_DATA_W'(sup_off));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(input int count, input int hold_at, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_req = 1'b1;
            if (i == pause_at)
                drain_results();
            offer_word(next_poll_word());
        end
    endtask

    initial begin
        t_in_word w;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk: accept while offline, exception reply from a device
        // never online, alarm and accept, bad byte count, retries running out,
        // grace window edges, and a time before the fault stamp.
        offer_word(make_word(FUNC_ACCEPT, 1'b1, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        offer_word(make_word(FUNC_POLL, 1'b1, FUNC_READ_INPUT, WANTED_BYTES, 16'h0001, 32'd5));
        offer_word(make_word(FUNC_POLL, 1'b0, EXC_FLAG | FUNC_READ_INPUT, WANTED_BYTES,
                             16'h0001, 32'd100));
        offer_word(make_word(FUNC_POLL, 1'b0, 8'h00, 8'h00, 16'h0000, 32'd110));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, WANTED_BYTES, 16'h0001, 32'd120));
        offer_word(make_word(FUNC_ACCEPT, 1'b0, 8'h00, 8'h00, 16'h0000, 32'd130));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, WANTED_BYTES, 16'hFFFE, 32'd140));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, 8'd3, 16'h0001, 32'd145));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, WANTED_BYTES, 16'hFFFF, 32'd150));
        offer_word(make_word(FUNC_POLL, 1'b0, EXC_FLAG | 8'h01, 8'h00, 16'h0000, 32'd160));
        repeat (5)
            offer_word(make_word(FUNC_POLL, 1'b1, 8'h00, 8'h00, 16'h0000, 32'd200));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, WANTED_BYTES, 16'h0001, 32'd260));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, 8'd0, 16'h0001, 32'd300));
        offer_word(make_word(FUNC_POLL, 1'b0, 8'hFF, 8'hFF, 16'hFFFF, 32'd1000));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, WANTED_BYTES, 16'h0001, 32'd1061));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, 8'd255, 16'h0001, 32'd2000));
        offer_word(make_word(FUNC_POLL, 1'b0, EXC_FLAG | FUNC_READ_INPUT, WANTED_BYTES,
                             16'h0001, 32'd5000));
        offer_word(make_word(FUNC_POLL, 1'b0, FUNC_READ_INPUT, WANTED_BYTES, 16'h0001, 32'd0));
        offer_word(make_word(FUNC_ACCEPT, 1'b1, 8'h00, 8'h00, 16'h0000, 32'd1));
        drain_results();

        configure(GRACE_DELAY_RST, RETRY_LIMIT_RST, SUPERVISION_OFF_RST);
        random_phase(220, 100, -1);
        drain_results();

        configure(32'd0, 8'd0, 1'b1);
        random_phase(130, -1, -1);
        drain_results();

        // The widest retry limit needs a long run of empty replies to exhaust.
        configure(32'hFFFF_FFFF, 8'd255, 1'b0);
        for (int i = 0; i < 260; i++) begin
            w = next_poll_word();
            w.func        = FUNC_POLL;
            w.reply_empty = 1'b1;
            offer_word(w);
        end
        random_phase(80, -1, -1);
        drain_results();

        configure(32'd30, 8'd1, 1'b0);
        random_phase(220, 40, 150);
        drain_results();

        configure(32'($urandom_range(0, 120)), 8'($urandom_range(0, 5)), 1'b1);
        random_phase(130, -1, -1);
        drain_results();

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== door_alarm_supervisor.f =====
design/das_pkg.sv
design/das_cfg.sv
design/das_core.sv
design/door_alarm_supervisor.sv
verif/door_alarm_supervisor_checker.sv
verif/door_alarm_supervisor_tb.sv
